/* hdl/rbd_pkg.sv */
package rbd_pkg;

  // Default sizes for the top-level parameters
  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths of the request and result transfers
  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  // Capacity register
  localparam int                 CAP_W     = 11;
  localparam int                 MIN_CAP   = 10;
  localparam logic [CAP_W-1:0]   CAP_RESET = 11'd1024;

  // Register port
  localparam int                 APB_DW   = 32;
  localparam int                 APB_AW   = 2;
  localparam logic [APB_AW-1:0]  CAP_ADDR = 2'd0;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_READ       = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_data;
    logic [COUNT_W-1:0]  element_count;
    logic [STATUS_W-1:0] status;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic capture;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic rd_hit;
  } sts_t;

endpackage

/* hdl/ring_buffer_deque.sv */
// A taken request is held in req_r and executed in S_EXEC; a read within range also passes S_RDWAIT,
// as the store's read port is registered. The result and out_strobe are registered. A new request
// is taken only while idle; busy stays high until the result is loaded.
// Results cannot be stalled and show for exactly one cycle on out_strobe.
// Reset empties the deque and sets capacity to 1024; store contents are not cleared.
module ring_buffer_deque #(
  parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rbd_pkg::in_t                 in_req,
  output logic                         out_strobe,
  output rbd_pkg::out_t                out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbd_pkg::APB_AW-1:0]   paddr,
  input  logic [rbd_pkg::APB_DW-1:0]   pwdata,
  output logic [rbd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  logic [rbd_pkg::CAP_W-1:0] cap_r;
  logic                      cfg_wr;
  rbd_pkg::ctl_t             ctl;
  rbd_pkg::sts_t             sts;

  // Decode a capacity write transfer
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == rbd_pkg::CAP_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= rbd_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[rbd_pkg::CAP_W-1:0];
    end
  end

  // Read back the capacity as written
  assign prdata = (paddr == rbd_pkg::CAP_ADDR) ? rbd_pkg::APB_DW'(cap_r) : '0;

  rbd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  rbd_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_req     (in_req),
    .cfg_wr     (cfg_wr),
    .cfg_cap    (pwdata[rbd_pkg::CAP_W-1:0]),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

/* hdl/rbd_ram.sv */
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/rbd_ctrl.sv */
module rbd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rbd_pkg::sts_t sts,
  output logic          busy,
  output rbd_pkg::ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_RDWAIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one request: take it, execute it, wait for the store on reads that hit
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = sts.rd_hit ? S_RDWAIT : S_IDLE;
      end
      S_RDWAIT: begin
        ctl.capture = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // A taken request always moves on to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept |=> state_r == S_EXEC)
    else $error("accepted request did not enter execution");

  // The read wait only follows a read that hit
  a_rdwait_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDWAIT |-> $past(state_r == S_EXEC && sts.rd_hit))
    else $error("read wait entered without a read hit");

  // Exactly one state bit is set
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

endmodule

/* hdl/rbd_datapath.sv */
module rbd_datapath #(
  parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rbd_pkg::ctl_t                ctl,
  output rbd_pkg::sts_t                sts,
  input  rbd_pkg::in_t                 in_req,
  input  logic                         cfg_wr,
  input  logic [rbd_pkg::CAP_W-1:0]    cfg_cap,
  output logic                         out_strobe,
  output rbd_pkg::out_t                out_data
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int NW  = (CW > rbd_pkg::CAP_W) ? CW : rbd_pkg::CAP_W;
  localparam int NW1 = NW + 1;
  localparam int XW  = (DATA_WIDTH > rbd_pkg::VALUE_W) ? DATA_WIDTH : rbd_pkg::VALUE_W;

  // Clamp the capacity to the usable ring size
  function automatic logic [NW-1:0] clamp_ring(input logic [rbd_pkg::CAP_W-1:0] cap);
    logic [NW-1:0] c;
    c = NW'(cap);
    if (c < NW'(rbd_pkg::MIN_CAP)) begin
      c = NW'(rbd_pkg::MIN_CAP);
    end else if (c > NW'(DEPTH)) begin
      c = NW'(DEPTH);
    end
    return c;
  endfunction

  rbd_pkg::in_t         req_r;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        tail_r, tail_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic [NW-1:0]        n_r;
  rbd_pkg::out_t        out_r, out_nxt;
  logic                 strobe_r, strobe_nxt;

  logic [NW-1:0]        head_up_w, tail_up_w;
  logic [AW-1:0]        head_up, head_dn, tail_up, tail_dn;
  logic [NW1-1:0]       rd_sum, rd_pos;
  logic                 full, empty, in_range, rd_hit;
  rbd_pkg::status_t     st;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [XW-1:0]        val_x, rd_x;

  // Neighbor slots of head and tail on the ring
  assign head_up_w = NW'(head_r) + NW'(1);
  assign tail_up_w = NW'(tail_r) + NW'(1);
  assign head_up   = (head_up_w >= n_r) ? '0 : AW'(head_up_w);
  assign tail_up   = (tail_up_w >= n_r) ? '0 : AW'(tail_up_w);
  assign head_dn   = (head_r == '0) ? AW'(n_r - NW'(1)) : head_r - AW'(1);
  assign tail_dn   = (tail_r == '0) ? AW'(n_r - NW'(1)) : tail_r - AW'(1);

  assign full  = (cnt_r >= n_r);
  assign empty = (cnt_r == '0);

  // Physical slot of a read, wrapped once
  assign rd_sum    = NW1'(head_r) + NW1'(req_r.index);
  assign rd_pos    = (rd_sum >= NW1'(n_r)) ? rd_sum - NW1'(n_r) : rd_sum;
  assign ram_raddr = AW'(rd_pos);
  assign in_range  = (NW'(req_r.index) < cnt_r);
  assign rd_hit    = (req_r.req_type == rbd_pkg::REQ_READ) && in_range;
  assign sts.rd_hit = rd_hit;

  // Fit the element to the store width and back
  assign val_x     = XW'(req_r.value);
  assign ram_wdata = val_x[DATA_WIDTH-1:0];
  assign rd_x      = XW'(ram_rdata);

  // Execute the request: pointers, count, store write, status; a capacity write empties the deque
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    st        = rbd_pkg::ST_OK;
    if (cfg_wr) begin
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
    end else if (ctl.exec) begin
      case (req_r.req_type)
        rbd_pkg::REQ_PUSH_BACK: begin
          if (full) begin
            st = rbd_pkg::ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tail_r;
            tail_nxt  = tail_up;
            cnt_nxt   = cnt_r + NW'(1);
          end
        end
        rbd_pkg::REQ_PUSH_FRONT: begin
          if (full) begin
            st = rbd_pkg::ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_dn;
            head_nxt  = head_dn;
            cnt_nxt   = cnt_r + NW'(1);
          end
        end
        rbd_pkg::REQ_POP_BACK: begin
          if (empty) begin
            st = rbd_pkg::ST_EMPTY;
          end else begin
            tail_nxt = tail_dn;
            cnt_nxt  = cnt_r - NW'(1);
          end
        end
        rbd_pkg::REQ_POP_FRONT: begin
          if (empty) begin
            st = rbd_pkg::ST_EMPTY;
          end else begin
            head_nxt = head_up;
            cnt_nxt  = cnt_r - NW'(1);
          end
        end
        rbd_pkg::REQ_READ: begin
          if (!in_range) begin
            st = rbd_pkg::ST_RANGE;
          end
        end
        default: begin
          st = rbd_pkg::ST_OK;
        end
      endcase
    end
  end

  // Load the result register from execution or from the store read
  always_comb begin
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    if (ctl.exec && !rd_hit) begin
      out_nxt.read_data     = '0;
      out_nxt.element_count = rbd_pkg::COUNT_W'(cnt_nxt);
      out_nxt.status        = st;
      strobe_nxt            = 1'b1;
    end else if (ctl.capture) begin
      out_nxt.read_data     = rd_x[rbd_pkg::VALUE_W-1:0];
      out_nxt.element_count = rbd_pkg::COUNT_W'(cnt_r);
      out_nxt.status        = rbd_pkg::ST_OK;
      strobe_nxt            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
      n_r      <= clamp_ring(rbd_pkg::CAP_RESET);
      strobe_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_wr) begin
        n_r <= clamp_ring(cfg_cap);
      end
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_r <= in_req;
    end
    out_r <= out_nxt;
  end

  rbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  // One request gives one result, never two in a row
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // The count never passes the ring size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= n_r)
    else $error("element count above ring size");

  // Head stays inside the ring
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    NW'(head_r) < n_r)
    else $error("head position outside ring");

endmodule
